// ===== design/lage_pkg.sv =====
package lage_pkg;

    // Widths wide enough for the largest allowed grid (256 rows, 1024 columns).
    localparam int NR_W = 9;
    localparam int NC_W = 11;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 128;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 13;
    localparam int GEN_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED   = 2'd2;

    localparam logic [3:0] SURVIVE_RST = 4'd3;
    localparam logic [5:0] ROWS_RST    = 6'd20;
    localparam logic [7:0] COLS_RST    = 8'd75;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_MIN = 4'd2;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_STEP  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic latch;
        logic clr_wr;
        logic row_clr;
        logic row_inc;
        logic col_clr;
        logic col_inc;
        logic rd_item;
        logic rd_cur;
        logic rd_plus1;
        logic rd_plus2;
        logic acc_wb;
        logic cnt_add;
        logic gen_inc;
        logic gen_load;
        logic gen_write;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  bad;
        logic  empty;
        logic  clr_last;
        logic  col_last;
        logic  row_last;
    } dp_stat_t;

endpackage

// ===== design/lage_dp.sv =====
module lage_dp
    import lage_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            func,
    input  logic [4:0]            row,
    input  logic [6:0]            col,
    input  logic                  live_in,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  cell_alive,
    output logic [COUNT_W-1:0]    live_count,
    output logic [GEN_W-1:0]      generation,
    output logic                  status
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [3:0]            survive_max_reg;
    logic [5:0]            rows_used_reg;
    logic [7:0]            cols_used_reg;
    func_t                 func_reg;
    logic [4:0]            row_reg;
    logic [6:0]            col_reg;
    logic                  live_in_reg;
    logic [NR_W-1:0]       row_cnt_reg;
    logic [NC_W-1:0]       col_cnt_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [GEN_W-1:0]      gen_reg;
    logic                  alive_reg;
    logic                  status_reg;
    logic [MAX_COLS-1:0]   rd_data_reg;
    logic [MAX_COLS-1:0]   up_reg;
    logic [MAX_COLS-1:0]   mid_reg;
    logic [MAX_COLS-1:0]   mem [MAX_ROWS];

    logic [NR_W-1:0]       nr;
    logic [NC_W-1:0]       nc;
    logic [NR_W-1:0]       row_p1;
    logic [NR_W-1:0]       row_p2;
    logic [NR_W-1:0]       item_row;
    logic [NC_W-1:0]       item_col;
    logic                  in_bad;
    logic                  rd_en;
    logic [NR_W-1:0]       rd_addr;
    logic                  wr_en;
    logic [NR_W-1:0]       wr_addr;
    logic [MAX_COLS-1:0]   wr_data;
    logic [MAX_COLS-1:0]   patched;
    logic [MAX_COLS-1:0]   col_mask;
    logic [MAX_COLS-1:0]   dn;
    logic [MAX_COLS-1:0]   new_row;
    logic [MAX_COLS+1:0]   up_p;
    logic [MAX_COLS+1:0]   mid_p;
    logic [MAX_COLS+1:0]   dn_p;

    // Effective area, clipped to the physical grid.
    assign nr = (NR_W'(rows_used_reg) > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS)
                                                         : NR_W'(rows_used_reg);
    assign nc = (NC_W'(cols_used_reg) > NC_W'(MAX_COLS)) ? NC_W'(MAX_COLS)
                                                         : NC_W'(cols_used_reg);

    assign row_p1   = row_cnt_reg + NR_W'(1);
    assign row_p2   = row_cnt_reg + NR_W'(2);
    assign item_row = NR_W'(row_reg);
    assign item_col = NC_W'(col_reg);

    assign in_bad = ((func == FUNC_WRITE) || (func == FUNC_READ)) &&
                    ((NR_W'(row) >= nr) || (NC_W'(col) >= nc));

    always_comb
    begin
        col_mask = '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (NC_W'(c) < nc);
        end
    end

    assign dn    = (row_p1 < nr) ? (rd_data_reg & col_mask) : '0;
    assign up_p  = {1'b0, up_reg & col_mask, 1'b0};
    assign mid_p = {1'b0, mid_reg & col_mask, 1'b0};
    assign dn_p  = {1'b0, dn, 1'b0};

    // Next state of one row; cells past the used columns keep their value.
    always_comb
    begin
        logic [3:0] n;
        new_row = mid_reg;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) +
                4'(mid_p[c]) + 4'(mid_p[c+2]) +
                4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
            if (col_mask[c])
            begin
                if (mid_reg[c])
                    new_row[c] = (n >= SURVIVE_MIN) && (n <= survive_max_reg);
                else
                    new_row[c] = (n == BIRTH_COUNT);
            end
        end
    end

    always_comb
    begin
        patched = rd_data_reg;
        patched[item_col[CW-1:0]] = live_in_reg;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = row_cnt_reg;
        if (cmd.rd_item)
        begin
            rd_en   = 1'b1;
            rd_addr = item_row;
        end
        else if (cmd.rd_cur)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.rd_plus1)
        begin
            rd_en   = (row_p1 < nr);
            rd_addr = row_p1;
        end
        else if (cmd.rd_plus2)
        begin
            rd_en   = (row_p2 < nr);
            rd_addr = row_p2;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_cnt_reg;
        wr_data = '0;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.acc_wb && (func_reg == FUNC_WRITE))
        begin
            wr_en   = 1'b1;
            wr_addr = item_row;
            wr_data = patched;
        end
        else if (cmd.gen_write)
        begin
            wr_en   = 1'b1;
            wr_data = new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[RW-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr[RW-1:0]];
        if (cmd.latch)
        begin
            func_reg    <= func_t'(func);
            row_reg     <= row;
            col_reg     <= col;
            live_in_reg <= live_in;
        end
        if (cmd.gen_load)
        begin
            up_reg  <= '0;
            mid_reg <= rd_data_reg;
        end
        else if (cmd.gen_write)
        begin
            up_reg  <= mid_reg;
            mid_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_max_reg <= SURVIVE_RST;
            rows_used_reg   <= ROWS_RST;
            cols_used_reg   <= COLS_RST;
            row_cnt_reg     <= '0;
            col_cnt_reg     <= '0;
            cnt_reg         <= '0;
            gen_reg         <= '0;
            alive_reg       <= 1'b0;
            status_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_SURVIVE_MAX: survive_max_reg <= cfg_data[3:0];
                    REG_ROWS_USED:   rows_used_reg   <= cfg_data[5:0];
                    REG_COLS_USED:   cols_used_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.latch || cmd.row_clr)
                row_cnt_reg <= '0;
            else if (cmd.row_inc)
                row_cnt_reg <= row_p1;
            if (cmd.col_clr)
                col_cnt_reg <= '0;
            else if (cmd.col_inc)
                col_cnt_reg <= col_cnt_reg + NC_W'(1);
            if (cmd.latch)
                cnt_reg <= '0;
            else if (cmd.cnt_add)
                cnt_reg <= cnt_reg + COUNT_W'(rd_data_reg[col_cnt_reg[CW-1:0]]);
            if (cmd.gen_inc)
                gen_reg <= gen_reg + GEN_W'(1);
            if (cmd.latch)
            begin
                alive_reg  <= 1'b0;
                status_reg <= in_bad;
            end
            else if (cmd.acc_wb && (func_reg == FUNC_READ))
            begin
                alive_reg <= rd_data_reg[item_col[CW-1:0]];
            end
        end
    end

    assign stat.func     = func_reg;
    assign stat.bad      = status_reg;
    assign stat.empty    = (nr == '0) || (nc == '0);
    assign stat.clr_last = (row_cnt_reg == NR_W'(MAX_ROWS - 1));
    assign stat.col_last = (col_cnt_reg == nc - NC_W'(1));
    assign stat.row_last = (row_p1 == nr);

    assign cell_alive = alive_reg;
    assign live_count = cnt_reg;
    assign generation = gen_reg;
    assign status     = status_reg;

endmodule

// ===== design/lage_ctrl.sv =====
module lage_ctrl
    import lage_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ACC_WB,
        S_GEN_LD,
        S_GEN_ROW,
        S_CNT_START,
        S_CNT_BITS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   busy_next;
    logic   done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.row_inc = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                    busy_next  = 1'b1;
                end
            end
            S_DISPATCH:
            begin
                if ((stat.func == FUNC_WRITE || stat.func == FUNC_READ) && !stat.bad)
                begin
                    cmd.rd_item = 1'b1;
                    state_next  = S_ACC_WB;
                end
                else if (stat.func == FUNC_STEP)
                begin
                    cmd.gen_inc = 1'b1;
                    if (stat.empty)
                    begin
                        state_next = S_CNT_START;
                    end
                    else
                    begin
                        cmd.rd_cur = 1'b1;
                        state_next = S_GEN_LD;
                    end
                end
                else
                begin
                    state_next = S_CNT_START;
                end
            end
            S_ACC_WB:
            begin
                cmd.acc_wb = 1'b1;
                state_next = S_CNT_START;
            end
            S_GEN_LD:
            begin
                cmd.gen_load = 1'b1;
                cmd.rd_plus1 = 1'b1;
                state_next   = S_GEN_ROW;
            end
            S_GEN_ROW:
            begin
                cmd.gen_write = 1'b1;
                cmd.rd_plus2  = 1'b1;
                cmd.row_inc   = 1'b1;
                if (stat.row_last)
                begin
                    cmd.row_clr = 1'b1;
                    state_next  = S_CNT_START;
                end
            end
            S_CNT_START:
            begin
                if (stat.empty)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
                else
                begin
                    cmd.rd_cur  = 1'b1;
                    cmd.col_clr = 1'b1;
                    state_next  = S_CNT_BITS;
                end
            end
            S_CNT_BITS:
            begin
                cmd.cnt_add = 1'b1;
                cmd.col_inc = 1'b1;
                if (stat.col_last)
                begin
                    cmd.col_clr = 1'b1;
                    cmd.row_inc = 1'b1;
                    if (stat.row_last)
                    begin
                        state_next = S_IDLE;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_plus1 = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("accepted item did not raise busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result strobe without an item in work");

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (state_reg == S_IDLE))
        else $error("not busy outside idle");
`endif

endmodule

// ===== design/life_automaton_generation_engine.sv =====
// A valid write or read reads the addressed row (a write also writes it back) and then
// counts the live cells; a generation step first updates every used row, and an ignored
// or unused item only counts. With an empty area every item skips the count pass.
// One item at a time: busy drops with the result, and the live count pass runs one
// cell per cycle. The receiver cannot stall a result.
// Reset: the grid store is cleared one row per cycle over all MAX_ROWS rows, busy high.
module life_automaton_generation_engine
    import lage_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic [4:0]            row,
    input  logic [6:0]            col,
    input  logic                  live_in,
    output logic                  done,
    output logic                  cell_alive,
    output logic [COUNT_W-1:0]    live_count,
    output logic [GEN_W-1:0]      generation,
    output logic                  status
);

    // The controller sequences every item: an optional row access, then for a
    // generation step one row per cycle through a three-row window, and finally
    // a pass that counts the live cells of the used area one cell per cycle.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    lage_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the grid rows in a memory, the configuration registers,
    // the counters and the registered result of the current item.
    lage_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .func       (func),
        .row        (row),
        .col        (col),
        .live_in    (live_in),
        .cmd        (cmd),
        .stat       (stat),
        .cell_alive (cell_alive),
        .live_count (live_count),
        .generation (generation),
        .status     (status)
    );

endmodule
